// File: rtl/tam_pkg.sv
// Shared types, constants and sine table math for the tremolo modulator.
package tam_pkg;

  localparam int SINE_SIZE_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int MAX_CHANNELS_DEF = 8;

  localparam int PERIOD_W = 17;
  localparam int DEPTH_W  = 7;
  localparam int COUNT_W  = 4;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 17'd9600;
  localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 7'd25;
  localparam logic [COUNT_W-1:0]  COUNT_RST  = 4'd1;
  localparam logic [DEPTH_W-1:0]  DEPTH_MAX  = 7'd100;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_DEPTH  = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  // floor(n/200) = (n * DIV200_MUL) >> DIV200_SHIFT for n < 2^23
  localparam int          PROD1_W      = 23;
  localparam int          DIV200_MUL_W = 24;
  localparam logic [23:0] DIV200_MUL   = 24'd10737419;
  localparam int          DIV200_SHIFT = 31;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [DEPTH_W-1:0]  depth;
    logic [COUNT_W-1:0]  count;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rom_rd;
    logic mul_depth;
    logic mul_recip;
    logic mul_gain;
    logic out_load;
  } ctrl_cmd_t;

  // Q15 sine of idx/2^lg turns: quadrant fold, Q30 Taylor series to x^11
  function automatic logic signed [15:0] sine_entry(input int unsigned idx,
                                                    input int unsigned lg);
    logic [63:0] frac;
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    frac = 64'(idx) << (32 - lg);
    quad = (frac >> 30) & 64'd3;
    r    = frac & (Q30_ONE - 64'd1);
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    x  = (r * PI_HALF_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return quad[1] ? -$signed(v[15:0]) : $signed(v[15:0]);
  endfunction

endpackage

// File: rtl/tam_regs.sv
// APB configuration registers: period, depth and channel count.
module tam_regs
  import tam_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [PERIOD_W-1:0] period_q;
  logic [DEPTH_W-1:0]  depth_q;
  logic [COUNT_W-1:0]  count_q;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      depth_q  <= DEPTH_RST;
      count_q  <= COUNT_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_PERIOD: period_q <= pwdata[PERIOD_W-1:0];
        REG_DEPTH:  depth_q  <= pwdata[DEPTH_W-1:0];
        REG_COUNT:  count_q  <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PERIOD: prdata = DATA_W'(period_q);
      REG_DEPTH:  prdata = DATA_W'(depth_q);
      REG_COUNT:  prdata = DATA_W'(count_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = '{period: period_q, depth: depth_q, count: count_q};

endmodule

// File: rtl/tam_ctrl.sv
// Sequencer: accept, phase division steps, table read, three multiplies, output.
module tam_ctrl
  import tam_pkg::*;
#(
  parameter int SINE_SIZE = SINE_SIZE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ctrl_cmd_t cmd_o
);

  localparam int LG     = $clog2(SINE_SIZE);
  localparam int STEP_W = $clog2(LG);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_ROM   = 7'b0000100,
    ST_MUL1  = 7'b0001000,
    ST_MUL2  = 7'b0010000,
    ST_MUL3  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_W'(LG - 1)) begin
          state_d = ST_ROM;
        end
      end
      ST_ROM: begin
        cmd_o.rom_rd = 1'b1;
        state_d      = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul_depth = 1'b1;
        state_d         = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_recip = 1'b1;
        state_d         = ST_MUL3;
      end
      ST_MUL3: begin
        cmd_o.mul_gain = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        // wait here until the output register is free
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/tam_dp.sv
// Datapath: LFO phase and channel state, phase divider, sine ROM, gain and product.
module tam_dp
  import tam_pkg::*;
#(
  parameter int SINE_SIZE    = SINE_SIZE_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctrl_cmd_t                     cmd_i,
  input  cfg_t                          cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          block_start_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  localparam int LG     = $clog2(SINE_SIZE);
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int PROD_W = SAMPLE_BITS + 18;
  localparam int RECIP_W = PROD1_W + DIV200_MUL_W;

  typedef logic signed [15:0] rom_t [SINE_SIZE];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int i = 0; i < SINE_SIZE; i++) begin
      rom[i] = sine_entry(unsigned'(i), unsigned'(LG));
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // control state
  logic [PERIOD_W-1:0] phase_q, phase_d;
  logic [CNT_W-1:0]    pos_q, pos_d;

  // payload
  logic [PERIOD_W:0]          rem_q;
  logic [PERIOD_W-1:0]        per_q;
  logic [LG-1:0]              quo_q;
  logic signed [15:0]         sin_q;
  logic [PROD1_W-1:0]         prod1_q;
  logic [15:0]                q200_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  logic [PERIOD_W-1:0] period_eff;
  logic [PERIOD_W-1:0] phase_use;
  logic [CNT_W-1:0]    chans_eff;
  logic [CNT_W-1:0]    pos_base;
  logic [CNT_W:0]      pos_inc;
  logic [DEPTH_W-1:0]  depth_eff;
  logic [PERIOD_W:0]   rem2;
  logic                rem_ge;
  logic [16:0]         biased;
  logic [RECIP_W-1:0]  recip;
  logic [16:0]         gain;
  logic signed [PROD_W-1:0] x_ext;
  logic signed [PROD_W-1:0] g_ext;
  logic signed [PROD_W-1:0] rnd_sum;

  always_comb begin
    period_eff = (cfg_i.period == '0) ? PERIOD_W'(1) : cfg_i.period;
    phase_use  = (phase_q >= period_eff) ? '0 : phase_q;

    if (cfg_i.count == '0) begin
      chans_eff = CNT_W'(1);
    end else if (32'(cfg_i.count) > 32'(MAX_CHANNELS)) begin
      chans_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      chans_eff = CNT_W'(cfg_i.count);
    end

    pos_base = block_start_i ? '0 : pos_q;
    pos_inc  = {1'b0, pos_base} + 1'b1;
    // a position at or past the count closes the frame
    if (pos_inc >= {1'b0, chans_eff}) begin
      pos_d   = '0;
      phase_d = phase_use + 1'b1;
    end else begin
      pos_d   = pos_inc[CNT_W-1:0];
      phase_d = phase_use;
    end

    depth_eff = (cfg_i.depth > DEPTH_MAX) ? DEPTH_MAX : cfg_i.depth;

    // restoring division, one quotient bit per step
    rem2   = {rem_q[PERIOD_W-1:0], 1'b0};
    rem_ge = rem2 >= {1'b0, per_q};

    biased  = 17'd32768 + {sin_q[15], sin_q};
    recip   = RECIP_W'(prod1_q) * RECIP_W'(DIV200_MUL);
    gain    = 17'd32768 - {1'b0, q200_q};
    x_ext   = PROD_W'(x_q);
    g_ext   = $signed(PROD_W'(gain));
    // truncate toward zero on the Q15 shift
    rnd_sum = prod_q + $signed({{(PROD_W - 15){1'b0}},
                               {15{prod_q[PROD_W-1]}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      pos_q   <= '0;
    end else if (cmd_i.load) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= {1'b0, phase_use};
      per_q <= period_eff;
      x_q   <= sample_in_i;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? (rem2 - {1'b0, per_q}) : rem2;
      quo_q <= {quo_q[LG-2:0], rem_ge};
    end
    if (cmd_i.rom_rd) begin
      sin_q <= SINE_ROM[quo_q];
    end
    if (cmd_i.mul_depth) begin
      prod1_q <= PROD1_W'(PROD1_W'(depth_eff) * PROD1_W'(biased));
    end
    if (cmd_i.mul_recip) begin
      q200_q <= recip[DIV200_SHIFT +: 16];
    end
    if (cmd_i.mul_gain) begin
      prod_q <= x_ext * g_ext;
    end
    if (cmd_i.out_load) begin
      out_q <= rnd_sum[SAMPLE_BITS+14:15];
    end
  end

  assign sample_out_o = out_q;

endmodule

// File: rtl/tremolo_amplitude_modulator.sv
// Top level of the sine LFO tremolo: registers, sequencer and datapath.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   sample_in_i, block_start_i
//   output    out        out_valid_o / out_stall_i sample_out_o
//   config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// One beat occupies the block from the accept through the phase division steps,
// the table read, the three multiplies and the output load; the next beat can be
// taken once the block is back in idle. The restoring phase divider, one quotient
// bit per cycle, makes up most of that sequence. A finished result sits in the
// output register, so the next beat is accepted while it waits; a new result waits
// for that slot. Reset clears phase, channel position and handshake state and loads
// the register defaults; the sine ROM is constant and needs no fill.
module tremolo_amplitude_modulator
  import tam_pkg::*;
#(
  parameter int SINE_SIZE    = SINE_SIZE_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          block_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;

  tam_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tam_ctrl #(
    .SINE_SIZE (SINE_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tam_dp #(
    .SINE_SIZE    (SINE_SIZE),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .sample_in_i   (sample_in_i),
    .block_start_i (block_start_i),
    .sample_out_o  (sample_out_o)
  );

`ifndef SYNTHESIS
  // an accepted beat keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result appears only at the end of a busy period
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work in flight");

  // while idle nothing refills the output register
  a_idle_no_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !in_stall_o |=> !out_valid_o)
    else $error("output refilled while idle");
`endif

endmodule

// File: tb/tremolo_amplitude_modulator_test.sv
// Self-checking testbench for the sine LFO tremolo: scoreboard class plus drivers.
import tam_pkg::*;

localparam logic [63:0] UNIT_Q30       = 64'd1073741824;
localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
localparam logic [63:0] ROUND_Q30      = 64'd536870912;
localparam int          LUT_DEPTH      = 1024;
localparam longint      GAIN_ONE       = 32768;
localparam longint      PHASE_WRAP     = 64'h1FFFF;
localparam int          CHANNELS_LIMIT = 8;

class tremolo_scoreboard;
  logic [16:0] period_reg;
  logic [6:0]  depth_reg;
  logic [3:0]  count_reg;
  longint      phase;
  longint      chan_pos;
  logic signed [15:0] sine_lut [LUT_DEPTH];
  logic signed [15:0] expected_q [$];
  int errors;
  int beats_in;
  int beats_out;

  function new();
    period_reg = 17'd9600;
    depth_reg  = 7'd25;
    count_reg  = 4'd1;
    phase      = 0;
    chan_pos   = 0;
    errors     = 0;
    beats_in   = 0;
    beats_out  = 0;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      sine_lut[i] = sine_q15(i);
    end
  endfunction

  // Q15 sine of i/LUT_DEPTH turns, folded to the first quadrant, Taylor to x^11
  function logic signed [15:0] sine_q15(int unsigned i);
    logic [63:0] frac, quad, r, x, x2, t, s, v;
    int m;
    frac = (64'(i) << 32) / 64'(LUT_DEPTH);
    quad = (frac >> 30) & 64'd3;
    r    = frac & (UNIT_Q30 - 64'd1);
    if (quad[0]) begin
      r = UNIT_Q30 - r;
    end
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = UNIT_Q30;
    t  = UNIT_Q30 - (((x2 * t) >> 30) / 64'd110);
    t  = UNIT_Q30 - (((x2 * t) >> 30) / 64'd72);
    t  = UNIT_Q30 - (((x2 * t) >> 30) / 64'd42);
    t  = UNIT_Q30 - (((x2 * t) >> 30) / 64'd20);
    t  = UNIT_Q30 - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + ROUND_Q30) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    m = int'(v[15:0]);
    return 16'(quad[1] ? -m : m);
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_PERIOD: period_reg = val[16:0];
      REG_DEPTH:  depth_reg  = val[6:0];
      REG_COUNT:  count_reg  = val[3:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] reg_value(logic [1:0] idx);
    case (idx)
      REG_PERIOD: return 32'(period_reg);
      REG_DEPTH:  return 32'(depth_reg);
      REG_COUNT:  return 32'(count_reg);
      default:    return 32'd0;
    endcase
  endfunction

  function int active_channels();
    if (count_reg == 4'd0) return 1;
    if (count_reg > CHANNELS_LIMIT) return CHANNELS_LIMIT;
    return int'(count_reg);
  endfunction

  // accepted input beat: advance the LFO and queue the scaled sample
  function void note_input(logic signed [15:0] smp, logic bs);
    longint per, dep, nch, idx, sv, gain, prod, y;
    per  = (period_reg == 17'd0) ? 1 : longint'(period_reg);
    dep  = (depth_reg > 7'd100) ? 100 : longint'(depth_reg);
    nch  = active_channels();
    if (bs) begin
      chan_pos = 0;
    end
    if (phase >= per) begin
      phase = 0;
    end
    idx  = (phase * LUT_DEPTH) / per;
    sv   = longint'(sine_lut[idx]);
    gain = GAIN_ONE - (dep * (GAIN_ONE + sv)) / 200;
    prod = longint'(smp) * gain;
    y    = prod / GAIN_ONE;
    expected_q.push_back(16'(y));
    beats_in++;
    chan_pos++;
    if (chan_pos >= nch) begin
      chan_pos = 0;
      phase = (phase + 1) & PHASE_WRAP;
    end
  endfunction

  function void check_output(logic signed [15:0] got);
    logic signed [15:0] want;
    beats_out++;
    if (expected_q.size() == 0) begin
      $error("sample_out: unexpected beat, expected none, actual %0d", got);
      errors++;
    end else begin
      want = expected_q.pop_front();
      if (got !== want) begin
        $error("sample_out mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tremolo_amplitude_modulator_test;
  localparam int SETTLE       = 40;
  localparam int TARGET_BEATS = 1650;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 250;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic signed [15:0]  sample_in_i;
  logic                block_start_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic signed [15:0]  sample_out_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  tremolo_amplitude_modulator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_in_i   (sample_in_i),
    .block_start_i (block_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_out_o  (sample_out_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  tremolo_scoreboard sb;
  bit burst_mode;
  bit pressure_done;
  int reg_writes;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 15);
    return $urandom_range(30, 90);
  endfunction

  task automatic send_beat(input logic signed [15:0] smp, input logic bs);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    sample_in_i   = smp;
    block_start_i = bs;
    do begin
      @(posedge clk_i);
      taken = !in_stall_o;
      if (taken) begin
        sb.note_input(smp, bs);
      end
      @(negedge clk_i);
    end while (!taken);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // write one register, then read it back
  task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    reg_writes++;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    if (got !== sb.reg_value(idx)) begin
      $error("prdata mismatch at register %0d: expected %0d, actual %0d",
             idx, sb.reg_value(idx), got);
      sb.errors++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // receiver: random stalls plus one long hold-off to back the block up
  initial begin
    int stall_left;
    int hold_left;
    int r;
    stall_left  = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      // start the hold-off while a result waits, a beat is in flight and another is offered
      if (!pressure_done && sb != null && sb.beats_in >= HOLD_AT &&
          in_valid_i && in_stall_o && out_valid_o) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!burst_mode) begin
        r = $urandom_range(0, 99);
        if (r < 20) stall_left = $urandom_range(1, 4);
        else if (r < 25) stall_left = $urandom_range(5, 15);
        else if (r < 27) stall_left = $urandom_range(30, 90);
      end
      out_stall_i = (hold_left > 0) || (stall_left > 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_output(sample_out_o);
    end
  end

  initial begin
    int k;
    int n_items;
    int blk;
    int r;
    int settings;
    int wait_n;
    int random_beats;
    bit well_formed;
    bit first;
    bit any;
    logic signed [15:0] smp;
    logic bs;
    logic [31:0] val;

    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    sample_in_i   = '0;
    block_start_i = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    burst_mode    = 1'b0;
    pressure_done = 1'b0;
    reg_writes    = 0;
    settings      = 1;
    random_beats  = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // reset settings, sample extremes
    send_beat(16'sh7FFF, 1'b1);
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh0000, 1'b0);
    send_beat(16'shFFFF, 1'b0);
    send_beat(16'sh0001, 1'b0);
    send_beat(16'sh5555, 1'b1);

    // zero period, depth above 100, zero channel count; junk in upper bits
    wait_idle();
    program_reg(REG_PERIOD, 32'hFFFE_0000);
    program_reg(REG_DEPTH, 32'h0000_FF7F);
    program_reg(REG_COUNT, 32'hFFFF_FFF0);
    settings++;
    send_beat(16'sh7FFF, 1'b0);
    send_beat(16'sh8000, 1'b1);
    send_beat(16'shAAAA, 1'b0);

    // full depth, count above the channel limit
    wait_idle();
    program_reg(REG_PERIOD, 32'd5);
    program_reg(REG_DEPTH, 32'd100);
    program_reg(REG_COUNT, 32'd15);
    settings++;
    for (k = 0; k < 10; k++) begin
      send_beat((k % 2) ? 16'sh8000 : 16'sh7FFF, k == 0);
    end

    // count lowered to the current channel position
    wait_idle();
    program_reg(REG_COUNT, 32'd2);
    program_reg(REG_PERIOD, 32'd131071);
    settings++;
    send_beat(16'sh7FFF, 1'b0);
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh1234, 1'b0);

    // period lowered under the current phase, no modulation
    wait_idle();
    program_reg(REG_PERIOD, 32'd2);
    program_reg(REG_DEPTH, 32'd0);
    settings++;
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh7FFF, 1'b1);

    first = 1'b1;
    while (random_beats < TARGET_BEATS) begin
      wait_idle();
      any = 1'b0;
      if (first || $urandom_range(0, 1)) begin
        r = $urandom_range(0, 9);
        case (r)
          0:       val = 32'd0;
          1:       val = 32'd131071;
          2, 3:    val = $urandom_range(1, 8);
          4, 5:    val = $urandom_range(9, 64);
          6, 7:    val = $urandom_range(65, 2000);
          8:       val = $urandom_range(2001, 131071);
          default: val = $urandom;
        endcase
        if ($urandom_range(0, 3) == 0) val = ($urandom & ~32'h1FFFF) | (val & 32'h1FFFF);
        program_reg(REG_PERIOD, val);
        any = 1'b1;
      end
      if (first || $urandom_range(0, 1)) begin
        r = $urandom_range(0, 5);
        case (r)
          0:       val = 32'd0;
          1:       val = 32'd100;
          2:       val = 32'd127;
          default: val = $urandom_range(0, 127);
        endcase
        if ($urandom_range(0, 3) == 0) val = ($urandom & ~32'h7F) | val;
        program_reg(REG_DEPTH, val);
        any = 1'b1;
      end
      if (first || !any || $urandom_range(0, 1)) begin
        r = $urandom_range(0, 5);
        case (r)
          0:       val = 32'd0;
          1:       val = 32'd15;
          2:       val = 32'd8;
          default: val = $urandom_range(1, 15);
        endcase
        if ($urandom_range(0, 3) == 0) val = ($urandom & ~32'hF) | val;
        program_reg(REG_COUNT, val);
      end
      first = 1'b0;
      settings++;

      burst_mode  = ($urandom_range(0, 4) == 0);
      well_formed = ($urandom_range(0, 4) != 0);
      blk         = $urandom_range(1, 8) * sb.active_channels();
      n_items     = $urandom_range(15, 70);
      for (k = 0; k < n_items; k++) begin
        if (well_formed) begin
          bs = (k % blk) == 0;
          if ($urandom_range(0, 32) == 0) bs = ~bs;
        end else begin
          bs = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 9) == 0) begin
          smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end else begin
          smp = 16'($urandom);
        end
        send_beat(smp, bs);
        random_beats++;
      end
      burst_mode = 1'b0;
    end

    in_valid_i = 1'b0;
    wait_n = 0;
    while (sb.pending() != 0 && wait_n < 100000) begin
      @(negedge clk_i);
      wait_n++;
    end
    if (sb.pending() != 0) begin
      $error("sample_out: %0d expected beats never arrived", sb.pending());
      sb.errors++;
    end
    repeat (SETTLE) @(negedge clk_i);

    $display("run covered %0d input beats and %0d output beats under %0d register settings",
             sb.beats_in, sb.beats_out, settings);
    $display("%0d register writes read back, one long output hold-off, %0d errors",
             reg_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
